// ===== design/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SCT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`endif

// ===== design/sct_pkg.sv =====
package sct_pkg;

  localparam int unsigned NumKw = 16;
  localparam int unsigned QueueDepth = 4;

  localparam logic [5:0] TEof     = 6'd0;
  localparam logic [5:0] TId      = 6'd1;
  localparam logic [5:0] TKwBase  = 6'd2;
  localparam logic [5:0] TInt     = 6'd18;
  localparam logic [5:0] TFloat   = 6'd19;
  localparam logic [5:0] TStr     = 6'd20;
  localparam logic [5:0] TComment = 6'd21;
  localparam logic [5:0] TGt      = 6'd37;
  localparam logic [5:0] TDiv     = 6'd34;
  localparam logic [5:0] TEq      = 6'd38;
  localparam logic [5:0] TEqEq    = 6'd39;
  localparam logic [5:0] TNe      = 6'd40;

  typedef struct packed {
    logic [5:0] tok_kind;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       token_end;
    logic       lex_error;
    logic       step_last;
  } result_t;

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0: return 4'd8;  4'd1: return 4'd6;  4'd2: return 4'd6;  4'd3: return 4'd4;
      4'd4: return 4'd4;  4'd5: return 4'd9;  4'd6: return 4'd3;  4'd7: return 4'd3;
      4'd8: return 4'd3;  4'd9: return 4'd2;  4'd10: return 4'd4; 4'd11: return 4'd5;
      4'd12: return 4'd3; 4'd13: return 4'd5; 4'd14: return 4'd6;
      default: return 4'd3;
    endcase
  endfunction

  // keyword text, padded with zero bytes
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] i);
    logic [71:0] s;
    logic [3:0]  j;
    case (k)
      4'd0:  s = "function";
      4'd1:  s = "number";
      4'd2:  s = "string";
      4'd3:  s = "void";
      4'd4:  s = "null";
      4'd5:  s = "undefined";
      4'd6:  s = "i32";
      4'd7:  s = "let";
      4'd8:  s = "var";
      4'd9:  s = "if";
      4'd10: s = "else";
      4'd11: s = "class";
      4'd12: s = "new";
      4'd13: s = "while";
      4'd14: s = "return";
      default: s = "for";
    endcase
    j = kw_len(k) - 4'd1 - i;
    if (i >= kw_len(k)) return 8'd0;
    return s[{j, 3'b000} +: 8];
  endfunction

  // single-byte punctuation, 0 when not one
  function automatic logic [5:0] punct_type(input logic [7:0] c);
    case (c)
      "(": return 6'd22; ")": return 6'd23; ":": return 6'd24; ",": return 6'd25;
      ".": return 6'd26; "[": return 6'd27; "]": return 6'd28; "{": return 6'd29;
      "}": return 6'd30; ";": return 6'd31; "+": return 6'd32; "-": return 6'd33;
      "*": return 6'd35; "<": return 6'd36; ">": return 6'd37;
      default: return 6'd0;
    endcase
  endfunction

endpackage

// ===== design/sct_stream_if.sv =====
interface sct_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/source_code_tokenizer_core.sv =====
// Streaming source tokenizer. Takes one source byte per cycle and returns token text bytes
// and token-end items; a byte that yields two results (closing "==", "!=", a held-back "*",
// a token end followed by a new token's first byte, an error or the end-of-text item, or an
// error before the end-of-text item) is queued as a pair and drains one result per cycle
// while the sink is ready. Throughput is one byte per cycle, set by the lexer state update;
// input stalls only when the four-entry result queue lacks room for a pair.
module source_code_tokenizer_core import sct_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input logic clk_i,
  input logic rst_ni,
  sct_stream_if.sink   in_if,
  sct_stream_if.source out_if
);
  logic       push, space;
  result_t    r0, r1, res;
  logic [1:0] rc;

  sct_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .ch_i(in_if.data),
    .push_o(push), .res0_o(r0), .res1_o(r1), .res_cnt_o(rc), .space_i(space)
  );

  sct_back #(.Depth(Depth)) u_back (
    .clk_i, .rst_ni,
    .push_i(push), .res0_i(r0), .res1_i(r1), .res_cnt_i(rc), .space_o(space),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_o(res)
  );

  assign out_if.data = res;

endmodule

// ===== design/sct_front.sv =====
// lexer state machine: one byte in, up to two results out as one push
module sct_front import sct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  output logic       push_o,
  output result_t    res0_o,
  output result_t    res1_o,
  output logic [1:0] res_cnt_o,
  input  logic       space_i
);
  typedef enum logic [3:0] {
    MIdle, MIdent, MInt, MFrac, MStr, MLine, MBlk, MBlkStar, MSlash, MEq, MBang, MHalt
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] alive_q, alive_d;
  logic [3:0]  len_q, len_d;
  logic        take;

  assign in_ready_o = space_i;
  assign take = in_valid_i && space_i;

  function automatic result_t mk(input logic [5:0] t, input logic [7:0] b,
                                 input logic hb, input logic e, input logic er);
    result_t r;
    r.tok_kind   = t;
    r.text_byte  = hb ? b : 8'd0;
    r.has_byte   = hb;
    r.token_end  = e;
    r.lex_error  = er;
    r.step_last  = 1'b0;
    return r;
  endfunction

  logic       is_dig, is_alp, is_ws;
  logic [5:0] pt;
  logic [5:0] id_type;
  logic [15:0] kw_next;

  assign is_dig = ch_i >= "0" && ch_i <= "9";
  assign is_alp = (ch_i >= "a" && ch_i <= "z") || (ch_i >= "A" && ch_i <= "Z");
  assign is_ws  = ch_i == " " || ch_i == 8'd10 || ch_i == 8'd13;
  assign pt     = punct_type(ch_i);

  always_comb begin
    kw_next = '0;
    for (int k = 0; k < NumKw; k++) begin
      if (alive_q[k] && len_q < kw_len(4'(k)) && kw_char(4'(k), len_q) == ch_i)
        kw_next[k] = 1'b1;
    end
  end

  always_comb begin
    id_type = TId;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (alive_q[k] && len_q == kw_len(4'(k))) begin
        id_type = TKwBase + 6'(k);
      end
    end
  end

  // results from the idle rule
  result_t    ir;
  logic       ir_v;
  mode_e      ir_mode;
  logic       ir_start_id;
  logic [15:0] first_alive;

  always_comb begin
    first_alive = '0;
    for (int k = 0; k < NumKw; k++)
      if (kw_char(4'(k), 4'd0) == ch_i) first_alive[k] = 1'b1;
  end

  always_comb begin
    ir = mk(TEof, 8'd0, 1'b0, 1'b0, 1'b0);
    ir_v = 1'b0;
    ir_mode = MIdle;
    ir_start_id = 1'b0;
    if (ch_i == 8'd0) begin
      ir = mk(TEof, 8'd0, 1'b0, 1'b1, 1'b0); ir_v = 1'b1;
    end else if (is_ws) begin
      ir_v = 1'b0;
    end else if (is_dig) begin
      ir = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); ir_v = 1'b1; ir_mode = MInt;
    end else if (is_alp) begin
      ir = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); ir_v = 1'b1; ir_mode = MIdent;
      ir_start_id = 1'b1;
    end else if (ch_i == "\"") ir_mode = MStr;
    else if (ch_i == "/") ir_mode = MSlash;
    else if (ch_i == "=") ir_mode = MEq;
    else if (ch_i == "!") ir_mode = MBang;
    else if (pt != 6'd0) begin
      ir = mk(pt, ch_i, 1'b1, 1'b1, 1'b0); ir_v = 1'b1;
    end else begin
      ir = mk(TEof, 8'd0, 1'b0, 1'b0, 1'b1); ir_v = 1'b1; ir_mode = MHalt;
    end
  end

  result_t    r0, r1;
  logic [1:0] cnt;
  logic       use_idle, do_kw, do_start;

  always_comb begin
    r0 = mk(TEof, 8'd0, 1'b0, 1'b0, 1'b0);
    r1 = r0;
    cnt = 2'd0;
    use_idle = 1'b0;
    do_kw = 1'b0;
    mode_d = mode_q;
    case (mode_q)
      MIdent: begin
        if (is_alp || is_dig) begin
          do_kw = 1'b1; r0 = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); cnt = 2'd1;
        end else begin
          r0 = mk(id_type, 8'd0, 1'b0, 1'b1, 1'b0); cnt = 2'd1; use_idle = 1'b1;
        end
      end
      MInt: begin
        if (is_dig) begin
          r0 = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); cnt = 2'd1;
        end else if (ch_i == ".") begin
          r0 = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); cnt = 2'd1; mode_d = MFrac;
        end else begin
          r0 = mk(TInt, 8'd0, 1'b0, 1'b1, 1'b0); cnt = 2'd1; use_idle = 1'b1;
        end
      end
      MFrac: begin
        if (is_dig) begin
          r0 = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); cnt = 2'd1;
        end else begin
          r0 = mk(TFloat, 8'd0, 1'b0, 1'b1, 1'b0); cnt = 2'd1; use_idle = 1'b1;
        end
      end
      MStr: begin
        if (ch_i == 8'd0) begin
          r0 = mk(TEof, 8'd0, 1'b0, 1'b0, 1'b1); cnt = 2'd1; use_idle = 1'b1;
        end else if (ch_i == "\"") begin
          r0 = mk(TStr, 8'd0, 1'b0, 1'b1, 1'b0); cnt = 2'd1; mode_d = MIdle;
        end else begin
          r0 = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); cnt = 2'd1;
        end
      end
      MLine: begin
        if (ch_i == 8'd10) begin
          r0 = mk(TComment, 8'd0, 1'b0, 1'b1, 1'b0); cnt = 2'd1; mode_d = MIdle;
        end else if (ch_i == 8'd0) begin
          r0 = mk(TComment, 8'd0, 1'b0, 1'b1, 1'b0); cnt = 2'd1; use_idle = 1'b1;
        end else begin
          r0 = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); cnt = 2'd1;
        end
      end
      MBlk, MBlkStar: begin
        if (ch_i == 8'd0) begin
          r0 = mk(TEof, 8'd0, 1'b0, 1'b0, 1'b1); cnt = 2'd1; use_idle = 1'b1;
        end else if (mode_q == MBlk) begin
          if (ch_i == "*") mode_d = MBlkStar;
          else begin
            r0 = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); cnt = 2'd1;
          end
        end else if (ch_i == "/") begin
          r0 = mk(TComment, 8'd0, 1'b0, 1'b1, 1'b0); cnt = 2'd1; mode_d = MIdle;
        end else if (ch_i == "*") begin
          r0 = mk(TEof, "*", 1'b1, 1'b0, 1'b0); cnt = 2'd1;
        end else begin
          r0 = mk(TEof, "*", 1'b1, 1'b0, 1'b0);
          r1 = mk(TEof, ch_i, 1'b1, 1'b0, 1'b0); cnt = 2'd2; mode_d = MBlk;
        end
      end
      MSlash: begin
        if (ch_i == "/") mode_d = MLine;
        else if (ch_i == "*") mode_d = MBlk;
        else begin
          r0 = mk(TDiv, "/", 1'b1, 1'b1, 1'b0); cnt = 2'd1; use_idle = 1'b1;
        end
      end
      MEq: begin
        if (ch_i == "=") begin
          r0 = mk(TEof, "=", 1'b1, 1'b0, 1'b0);
          r1 = mk(TEqEq, "=", 1'b1, 1'b1, 1'b0); cnt = 2'd2; mode_d = MIdle;
        end else begin
          r0 = mk(TEq, "=", 1'b1, 1'b1, 1'b0); cnt = 2'd1; use_idle = 1'b1;
        end
      end
      MBang: begin
        if (ch_i == "=") begin
          r0 = mk(TEof, "!", 1'b1, 1'b0, 1'b0);
          r1 = mk(TNe, "=", 1'b1, 1'b1, 1'b0); cnt = 2'd2; mode_d = MIdle;
        end else begin
          r0 = mk(TEof, 8'd0, 1'b0, 1'b0, 1'b1); cnt = 2'd1;
          if (ch_i == 8'd0) use_idle = 1'b1;
          else mode_d = MHalt;
        end
      end
      MHalt: begin
        if (ch_i == 8'd0) use_idle = 1'b1;
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase
    do_start = use_idle && ir_start_id;
    if (use_idle) begin
      mode_d = ir_mode;
      if (ir_v) begin
        if (cnt == 2'd0) begin
          r0 = ir; cnt = 2'd1;
        end else begin
          r1 = ir; cnt = 2'd2;
        end
      end
    end
    if (cnt == 2'd1) r0.step_last = 1'b1;
    if (cnt == 2'd2) r1.step_last = 1'b1;
  end

  always_comb begin
    alive_d = alive_q;
    len_d = len_q;
    if (do_start) begin
      alive_d = first_alive; len_d = 4'd1;
    end else if (do_kw) begin
      alive_d = kw_next;
      if (len_q != 4'd15) len_d = len_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle;
      alive_q <= '0;
      len_q <= '0;
    end else if (take) begin
      mode_q <= mode_d;
      alive_q <= alive_d;
      len_q <= len_d;
    end
  end

  assign push_o = take && cnt != 2'd0;
  assign res0_o = r0;
  assign res1_o = r1;
  assign res_cnt_o = cnt;

endmodule

// ===== design/sct_back.sv =====
`include "assert_macros.svh"
// result queue: takes one or two results per push, delivers one per cycle while the sink is ready
module sct_back import sct_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  result_t    res0_i,
  input  result_t    res1_i,
  input  logic [1:0] res_cnt_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_o
);
  localparam int unsigned Aw = $clog2(Depth);

  result_t            mem_q [Depth];
  logic [Aw-1:0]      wp_q, rp_q;
  logic [Aw:0]        cnt_q, cnt_d;
  logic               pop;
  logic [Aw:0]        add;

  assign pop = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_o = mem_q[rp_q];
  // room for two entries even with no pop this cycle
  assign space_o = cnt_q <= (Aw+1)'(Depth - 2);
  assign add = push_i ? (Aw+1)'(res_cnt_i) : '0;
  assign cnt_d = cnt_q + add - (Aw+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= res0_i;
      if (res_cnt_i == 2'd2) mem_q[Aw'(wp_q + Aw'(1))] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_q + Aw'(add);
      if (pop) rp_q <= rp_q + Aw'(1);
      cnt_q <= cnt_d;
    end
  end

  `SCT_ASSERT(a_no_overflow, clk_i, rst_ni, cnt_q <= (Aw+1)'(Depth), "queue overflow")
  `SCT_ASSERT(a_push_room, clk_i, rst_ni, push_i |-> space_o, "push without room")
  `SCT_ASSERT(a_pair_last, clk_i, rst_ni,
              push_i && res_cnt_i == 2'd2 |-> !res0_i.step_last && res1_i.step_last,
              "pair step_last misplaced")

endmodule

// ===== test/source_code_tokenizer_core_chk.sv =====
module source_code_tokenizer_core_chk import sct_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_ready_i,
  input  logic [7:0] in_data_i,
  input  logic    out_valid_i,
  input  logic    out_ready_i,
  input  result_t out_data_i,
  output int      fail_count_o,
  output int      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    LxIdle, LxIdent, LxInt, LxFrac, LxStr, LxLine, LxBlk, LxBlkStar,
    LxSlash, LxEq, LxBang, LxHalt
  } lex_mode_e;

  lex_mode_e   mode_q;
  logic [15:0] kw_alive_q;
  logic [3:0]  id_len_q;
  result_t     token_queue[$];
  int          fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = token_queue.size();

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] keyword_byte(int k, int i);
    string words[16] = '{"function", "number", "string", "void", "null", "undefined",
                         "i32", "let", "var", "if", "else", "class", "new", "while",
                         "return", "for"};
    if (i >= words[k].len()) return 8'd0;
    return words[k][i];
  endfunction

  function automatic int keyword_len(int k);
    int lens[16] = '{8, 6, 6, 4, 4, 9, 3, 3, 3, 2, 4, 5, 3, 5, 6, 3};
    return lens[k];
  endfunction

  task automatic push_token(logic [5:0] ty, logic [7:0] b, bit hb, bit te, bit err);
    result_t r;
    r.tok_kind   = ty;
    r.text_byte  = hb ? b : 8'd0;
    r.has_byte   = hb;
    r.token_end  = te;
    r.lex_error  = err;
    r.step_last  = 1'b0;
    token_queue.push_back(r);
  endtask

  task automatic advance_keywords(logic [7:0] c);
    logic [15:0] nxt;
    nxt = '0;
    for (int k = 0; k < 16; k++)
      if (kw_alive_q[k] && id_len_q < keyword_len(k) && keyword_byte(k, id_len_q) == c)
        nxt[k] = 1'b1;
    kw_alive_q = nxt;
    if (id_len_q < 4'd15) id_len_q++;
  endtask

  function automatic logic [5:0] ident_kind();
    for (int k = 0; k < 16; k++)
      if (kw_alive_q[k] && id_len_q == keyword_len(k)) return TKwBase + 6'(k);
    return TId;
  endfunction

  task automatic lex_from_idle(logic [7:0] c);
    logic [5:0] pt;
    mode_q = LxIdle;
    pt = punct_type(c);
    if (c == 8'd0) push_token(TEof, 0, 0, 1, 0);
    else if (c == " " || c == 8'd10 || c == 8'd13) ;
    else if (is_digit(c)) begin
      mode_q = LxInt;
      push_token(0, c, 1, 0, 0);
    end else if (is_alpha(c)) begin
      mode_q = LxIdent;
      kw_alive_q = '1;
      id_len_q = '0;
      advance_keywords(c);
      push_token(0, c, 1, 0, 0);
    end else if (c == "\"") mode_q = LxStr;
    else if (c == "/") mode_q = LxSlash;
    else if (c == "=") mode_q = LxEq;
    else if (c == "!") mode_q = LxBang;
    else if (pt != 6'd0) push_token(pt, c, 1, 1, 0);
    else begin
      mode_q = LxHalt;
      push_token(0, 0, 0, 0, 1);
    end
  endtask

  task automatic predict_tokens(logic [7:0] c);
    int n0;
    n0 = token_queue.size();
    case (mode_q)
      LxIdent:
        if (is_alpha(c) || is_digit(c)) begin
          advance_keywords(c);
          push_token(0, c, 1, 0, 0);
        end else begin
          push_token(ident_kind(), 0, 0, 1, 0);
          lex_from_idle(c);
        end
      LxInt:
        if (is_digit(c)) push_token(0, c, 1, 0, 0);
        else if (c == ".") begin
          mode_q = LxFrac;
          push_token(0, c, 1, 0, 0);
        end else begin
          push_token(TInt, 0, 0, 1, 0);
          lex_from_idle(c);
        end
      LxFrac:
        if (is_digit(c)) push_token(0, c, 1, 0, 0);
        else begin
          push_token(TFloat, 0, 0, 1, 0);
          lex_from_idle(c);
        end
      LxStr:
        if (c == 8'd0) begin
          push_token(0, 0, 0, 0, 1);
          lex_from_idle(c);
        end else if (c == "\"") begin
          mode_q = LxIdle;
          push_token(TStr, 0, 0, 1, 0);
        end else push_token(0, c, 1, 0, 0);
      LxLine:
        if (c == 8'd10) begin
          mode_q = LxIdle;
          push_token(TComment, 0, 0, 1, 0);
        end else if (c == 8'd0) begin
          push_token(TComment, 0, 0, 1, 0);
          lex_from_idle(c);
        end else push_token(0, c, 1, 0, 0);
      LxBlk, LxBlkStar:
        if (c == 8'd0) begin
          push_token(0, 0, 0, 0, 1);
          lex_from_idle(c);
        end else if (mode_q == LxBlk) begin
          if (c == "*") mode_q = LxBlkStar;
          else push_token(0, c, 1, 0, 0);
        end else if (c == "/") begin
          mode_q = LxIdle;
          push_token(TComment, 0, 0, 1, 0);
        end else if (c == "*") push_token(0, "*", 1, 0, 0);
        else begin
          mode_q = LxBlk;
          push_token(0, "*", 1, 0, 0);
          push_token(0, c, 1, 0, 0);
        end
      LxSlash:
        if (c == "/") mode_q = LxLine;
        else if (c == "*") mode_q = LxBlk;
        else begin
          push_token(TDiv, "/", 1, 1, 0);
          lex_from_idle(c);
        end
      LxEq:
        if (c == "=") begin
          mode_q = LxIdle;
          push_token(0, "=", 1, 0, 0);
          push_token(TEqEq, "=", 1, 1, 0);
        end else begin
          push_token(TEq, "=", 1, 1, 0);
          lex_from_idle(c);
        end
      LxBang:
        if (c == "=") begin
          mode_q = LxIdle;
          push_token(0, "!", 1, 0, 0);
          push_token(TNe, "=", 1, 1, 0);
        end else begin
          push_token(0, 0, 0, 0, 1);
          if (c == 8'd0) lex_from_idle(c);
          else mode_q = LxHalt;
        end
      LxHalt:
        if (c == 8'd0) lex_from_idle(c);
      default: lex_from_idle(c);
    endcase
    if (token_queue.size() > n0) token_queue[$].step_last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      mode_q     = LxIdle;
      kw_alive_q = '0;
      id_len_q   = '0;
      fail_count = 0;
      token_queue.delete();
    end else begin
      // check before predicting: a result never leaves in the cycle its byte enters
      if (out_valid_i && out_ready_i) begin
        if (token_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data_i);
        end else begin
          want = token_queue.pop_front();
          if (out_data_i !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_tokens(in_data_i);
    end
  end
endmodule

// ===== test/source_code_tokenizer_core_tb.sv =====
module source_code_tokenizer_core_tb import sct_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  bit   feed_done = 1'b0;

  sct_stream_if #(.payload_t(logic [7:0])) in_if ();
  sct_stream_if #(.payload_t(result_t))    out_if ();

  source_code_tokenizer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  source_code_tokenizer_core_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // random sink stall pattern, ready drawn anew each cycle
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 9) < 2) out_if.ready <= 1'b1;
      else out_if.ready <= (gap_len() == 0);
    end
  end

  string src_text;

  task automatic send_byte(logic [7:0] c);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= c;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(8'd0);
  endtask

  function automatic string rand_piece();
    string words[] = '{"function", "number", "string", "void", "null", "undefined", "i32",
                       "let", "var", "if", "else", "class", "new", "while", "return", "for",
                       "fo", "whilex", "abcdefghijklmnopq", "X9", "z", "elsea", "i3"};
    string pieces[] = '{" ", "\n", "\015", "42", "3.14", "7.", "\"ab c\"", "\"\"", "// hi\n",
                        "/* a*b **/", "/**/", "/", "=", "==", "!=", "(", ")", ":", ",", ".",
                        "[", "]", "{", "}", ";", "+", "-", "*", "<", ">"};
    if ($urandom_range(0, 2) == 0) return words[$urandom_range(0, words.size() - 1)];
    return pieces[$urandom_range(0, pieces.size() - 1)];
  endfunction

  initial begin
    int sent;
    byte unsigned b;
    in_if.valid = 1'b0;
    in_if.data  = 8'd0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_text("function number string void null undefined i32 let var if else class");
    send_text("new while return for foo Zq9 0123456789 12.5 8. \"\" \"x\"");
    send_text("a//line\n/*bl*ck**/ / = == != ()[]{}:;,.+-*<>");
    send_text("\"open");
    send_text("/* open *");
    send_text("// eof");
    send_text("!x more");
    send_text("!");
    send_text("a\tb");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'd0);
    send_text("@");

    sent = 0;
    while (sent < 1640) begin
      src_text = "";
      repeat ($urandom_range(1, 12)) src_text = {src_text, rand_piece()};
      if ($urandom_range(0, 7) == 0) begin
        b = $urandom_range(1, 255);
        src_text = {src_text, string'(b)};
      end
      if ($urandom_range(0, 9) == 0) src_text = {src_text, "\"unterminated"};
      if ($urandom_range(0, 9) == 0) src_text = {src_text, "/* open *"};
      send_text(src_text);
      sent += src_text.len() + 1;
    end
    in_if.valid <= 1'b0;
    feed_done = 1'b1;
  end

  initial begin
    wait (feed_done);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end
endmodule
